FILE: design/pal_pkg.sv
// shared types and constants for the positional array list
// no dependencies
`timescale 1ns / 1ps

package pal_pkg;

    localparam int KEY_W   = 32;
    localparam int POS_W   = 8;
    localparam int OP_W    = 3;
    localparam int CAP_W   = 5;
    localparam int CNTO_W  = 5;
    localparam int KIND_W  = 2;

    // opcodes
    localparam logic [OP_W-1:0] OP_INS_AT    = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_FIRST = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_LAST  = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_AT    = 3'd3;
    localparam logic [OP_W-1:0] OP_REM_FIRST = 3'd4;
    localparam logic [OP_W-1:0] OP_REM_LAST  = 3'd5;
    localparam logic [OP_W-1:0] OP_LIST      = 3'd6;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LIST   = 2'd2;

    // cell source select
    typedef logic [2:0] t_cell_sel;
    localparam t_cell_sel SEL_HOLD = 3'd0;
    localparam t_cell_sel SEL_LOAD = 3'd1;
    localparam t_cell_sel SEL_PREV = 3'd2;
    localparam t_cell_sel SEL_NEXT = 3'd3;
    localparam t_cell_sel SEL_HEAD = 3'd4;

    typedef logic [KEY_W-1:0] t_key;

endpackage

FILE: design/pal_cell.sv
// one storage cell of the list chain: holds a single key
// depends on pal_pkg
`timescale 1ns / 1ps

module pal_cell (
    input  logic             i_clk,
    input  pal_pkg::t_cell_sel i_sel,
    input  pal_pkg::t_key    i_key,
    input  pal_pkg::t_key    i_prev,
    input  pal_pkg::t_key    i_next,
    input  pal_pkg::t_key    i_head,
    output pal_pkg::t_key    o_slot
);

    pal_pkg::t_key r_slot;
    pal_pkg::t_key n_slot;

    always_comb begin
        case (i_sel)
            pal_pkg::SEL_LOAD: n_slot = i_key;
            pal_pkg::SEL_PREV: n_slot = i_prev;
            pal_pkg::SEL_NEXT: n_slot = i_next;
            pal_pkg::SEL_HEAD: n_slot = i_head;
            default:           n_slot = r_slot;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot = r_slot;

endmodule

FILE: design/positional_array_list_top.sv
// top level of the positional array list: control, output register, cell chain
// depends on pal_pkg and pal_cell
`timescale 1ns / 1ps

// Ordered list of signed 32-bit keys kept contiguously from slot 0 in a chain
// of MAX_DEPTH register cells. Inserts and removes (at a position, the front
// or the end) are done in a single step: every cell picks its left or right
// neighbour in the same clock, so the whole tail moves at once, and each
// gives one result beat. A list operation gives one beat per stored key: it
// is started first, then while the output is free the chain rotates by one
// slot per cycle and the head cell feeds the output, so after the last
// beat the keys are back in order.
// While a list is in progress the input is stalled. An empty list gives no
// beat. A single output register separates the two sides, so a new item is
// taken in the cycle its predecessor's beat leaves. The capacity register
// (reset 16) caps the count together with MAX_DEPTH; lowering it below the
// current count only blocks inserts. Rejected operations report status 1
// and leave the list untouched. Slot contents need no reset.

module positional_array_list_top #(
    parameter int MAX_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [pal_pkg::CAP_W-1:0]   i_cfg_data,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [pal_pkg::OP_W-1:0]    i_opcode,
    input  logic signed [pal_pkg::KEY_W-1:0] i_key_in,
    input  logic [pal_pkg::POS_W-1:0]   i_position,
    // output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [pal_pkg::KEY_W-1:0] o_key_out,
    output logic                        o_status,
    output logic [pal_pkg::CNTO_W-1:0]  o_count_after,
    output logic [pal_pkg::KIND_W-1:0]  o_result_kind,
    output logic                        o_last
);

    localparam int CW   = $clog2(MAX_DEPTH + 1);
    localparam int IW   = $clog2(MAX_DEPTH);
    // compare width covers count, position and capacity
    localparam int CMPW = (CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W;

    // control state
    logic [CW-1:0]               r_count, n_count;
    logic [pal_pkg::CAP_W-1:0]   r_cap;
    logic                        r_listing, n_listing;
    logic [CW-1:0]               r_left, n_left;

    // output register
    logic                        r_out_valid, n_out_valid;
    pal_pkg::t_key               r_out_key, n_out_key;
    logic                        r_out_status, n_out_status;
    logic [pal_pkg::CNTO_W-1:0]  r_out_cnt, n_out_cnt;
    logic [pal_pkg::KIND_W-1:0]  r_out_kind, n_out_kind;
    logic                        r_out_last, n_out_last;

    // chain
    pal_pkg::t_key               w_slot [MAX_DEPTH];
    pal_pkg::t_cell_sel          w_sel  [MAX_DEPTH];

    logic                        w_out_free;
    logic                        w_accept;
    logic                        w_step;
    logic                        w_is_ins, w_is_rem;
    logic [CMPW-1:0]             w_cnt, w_pos, w_cap, w_peff;
    logic                        w_full;
    logic                        w_ins_ok, w_rem_ok;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = r_listing || !w_out_free;
    assign w_accept   = i_valid && !o_stall;
    assign w_step     = r_listing && w_out_free;

    assign w_cnt = CMPW'(r_count);
    assign w_pos = CMPW'(i_position);
    assign w_cap = CMPW'(r_cap);
    assign w_full = (w_cnt >= w_cap) || (w_cnt >= CMPW'(MAX_DEPTH));

    // opcode decode and effective position
    always_comb begin
        w_is_ins = 1'b0;
        w_is_rem = 1'b0;
        w_peff   = w_pos;
        unique case (i_opcode) inside
            pal_pkg::OP_INS_AT, pal_pkg::OP_INS_FIRST, pal_pkg::OP_INS_LAST: begin
                w_is_ins = 1'b1;
            end
            pal_pkg::OP_REM_AT, pal_pkg::OP_REM_FIRST, pal_pkg::OP_REM_LAST: begin
                w_is_rem = 1'b1;
            end
            default: begin
                // list, unused code treated as list
            end
        endcase
        case (i_opcode)
            pal_pkg::OP_INS_FIRST, pal_pkg::OP_REM_FIRST: w_peff = '0;
            pal_pkg::OP_INS_LAST:                         w_peff = w_cnt;
            pal_pkg::OP_REM_LAST: w_peff = (w_cnt == '0) ? '0 : w_cnt - CMPW'(1);
            default:                                      w_peff = w_pos;
        endcase
    end

    assign w_ins_ok = w_is_ins && !w_full && (w_peff <= w_cnt);
    assign w_rem_ok = w_is_rem && (w_cnt != '0) && (w_peff < w_cnt);

    // per-cell source select
    for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_ctl
        localparam logic [CMPW-1:0] IDX = CMPW'(g);
        always_comb begin
            w_sel[g] = pal_pkg::SEL_HOLD;
            if (w_accept && w_ins_ok) begin
                if (IDX == w_peff) begin
                    w_sel[g] = pal_pkg::SEL_LOAD;
                end else if (IDX > w_peff && IDX <= w_cnt) begin
                    w_sel[g] = pal_pkg::SEL_PREV;
                end
            end else if (w_accept && w_rem_ok) begin
                if (IDX >= w_peff && IDX + CMPW'(1) < w_cnt) begin
                    w_sel[g] = pal_pkg::SEL_NEXT;
                end
            end else if (w_step) begin
                // rotate by one, head wraps to the tail
                if (IDX + CMPW'(1) < w_cnt) begin
                    w_sel[g] = pal_pkg::SEL_NEXT;
                end else if (IDX + CMPW'(1) == w_cnt) begin
                    w_sel[g] = pal_pkg::SEL_HEAD;
                end
            end
        end
    end

    for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
        pal_pkg::t_key w_prev;
        pal_pkg::t_key w_next;
        if (g == 0) begin : g_first
            assign w_prev = i_key_in;
        end else begin : g_mid
            assign w_prev = w_slot[g-1];
        end
        if (g == MAX_DEPTH - 1) begin : g_lastc
            assign w_next = w_slot[g];
        end else begin : g_notlast
            assign w_next = w_slot[g+1];
        end
        pal_cell u_cell (
            .i_clk  (i_clk),
            .i_sel  (w_sel[g]),
            .i_key  (i_key_in),
            .i_prev (w_prev),
            .i_next (w_next),
            .i_head (w_slot[0]),
            .o_slot (w_slot[g])
        );
    end

    // next state and output register
    always_comb begin
        n_count      = r_count;
        n_listing    = r_listing;
        n_left       = r_left;
        n_out_valid  = r_out_valid && i_stall;
        n_out_key    = r_out_key;
        n_out_status = r_out_status;
        n_out_cnt    = r_out_cnt;
        n_out_kind   = r_out_kind;
        n_out_last   = r_out_last;

        if (w_accept) begin
            if (w_is_ins) begin
                n_count      = w_ins_ok ? r_count + CW'(1) : r_count;
                n_out_valid  = 1'b1;
                n_out_key    = '0;
                n_out_status = !w_ins_ok;
                n_out_cnt    = pal_pkg::CNTO_W'(n_count);
                n_out_kind   = pal_pkg::KIND_INSERT;
                n_out_last   = 1'b1;
            end else if (w_is_rem) begin
                n_count      = w_rem_ok ? r_count - CW'(1) : r_count;
                n_out_valid  = 1'b1;
                n_out_key    = w_rem_ok ? w_slot[w_peff[IW-1:0]] : '0;
                n_out_status = !w_rem_ok;
                n_out_cnt    = pal_pkg::CNTO_W'(n_count);
                n_out_kind   = pal_pkg::KIND_REMOVE;
                n_out_last   = 1'b1;
            end else if (r_count != '0) begin
                n_listing = 1'b1;
                n_left    = r_count;
            end
        end else if (w_step) begin
            n_out_valid  = 1'b1;
            n_out_key    = w_slot[0];
            n_out_status = 1'b0;
            n_out_cnt    = pal_pkg::CNTO_W'(r_count);
            n_out_kind   = pal_pkg::KIND_LIST;
            n_out_last   = (r_left == CW'(1));
            n_left       = r_left - CW'(1);
            n_listing    = (r_left != CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= pal_pkg::CAP_W'(16);
            r_listing   <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_listing   <= n_listing;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    // beat payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_out_key    <= n_out_key;
        r_out_status <= n_out_status;
        r_out_cnt    <= n_out_cnt;
        r_out_kind   <= n_out_kind;
        r_out_last   <= n_out_last;
    end

    assign o_valid       = r_out_valid;
    assign o_key_out     = r_out_key;
    assign o_status      = r_out_status;
    assign o_count_after = r_out_cnt;
    assign o_result_kind = r_out_kind;
    assign o_last        = r_out_last;

endmodule

FILE: bench/positional_array_list_checker.sv
// result checker for the positional array list: watches both channels and the capacity port,
// keeps a shadow copy of the list and compares every result beat with the predicted one
// depends on pal_pkg
`timescale 1ns / 1ps

module positional_array_list_checker #(
    parameter int MAX_DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pal_pkg::CAP_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [pal_pkg::OP_W-1:0]        i_opcode,
    input  pal_pkg::t_key                   i_key_in,
    input  logic [pal_pkg::POS_W-1:0]       i_position,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  pal_pkg::t_key                   i_key_out,
    input  logic                            i_status,
    input  logic [pal_pkg::CNTO_W-1:0]      i_count_after,
    input  logic [pal_pkg::KIND_W-1:0]      i_result_kind,
    input  logic                            i_last,
    output int                              o_errors,
    output int                              o_outstanding,
    output int                              o_stored,
    output int                              o_beats_seen
);

    typedef struct packed {
        pal_pkg::t_key                  key;
        logic                           status;
        logic [pal_pkg::CNTO_W-1:0]     count_after;
        logic [pal_pkg::KIND_W-1:0]     kind;
        logic                           last;
    } t_list_beat;

    t_list_beat    awaited_beats[$];
    t_list_beat    oldest_beat;
    pal_pkg::t_key shadow_slots [MAX_DEPTH];
    int            shadow_count;
    int            shadow_cap;

    task automatic push_beat(input pal_pkg::t_key key, input logic rejected,
                             input logic [pal_pkg::KIND_W-1:0] kind, input logic last);
        t_list_beat b;
        b.key         = key;
        b.status      = rejected;
        b.count_after = shadow_count[pal_pkg::CNTO_W-1:0];
        b.kind        = kind;
        b.last        = last;
        awaited_beats.push_back(b);
    endtask

    // applies one accepted item to the shadow list and queues its result beats
    task automatic apply_item(input logic [pal_pkg::OP_W-1:0] op, input pal_pkg::t_key key,
                              input int pos);
        int            where;
        int            i;
        int            room;
        pal_pkg::t_key taken;
        logic          done;
        taken = '0;
        done  = 1'b0;
        room  = (shadow_cap < MAX_DEPTH) ? shadow_cap : MAX_DEPTH;
        case (op)
            pal_pkg::OP_INS_AT, pal_pkg::OP_INS_FIRST, pal_pkg::OP_INS_LAST: begin
                where = (op == pal_pkg::OP_INS_FIRST) ? 0 :
                        (op == pal_pkg::OP_INS_LAST)  ? shadow_count : pos;
                if (shadow_count < room && where <= shadow_count) begin
                    for (i = shadow_count; i > where; i--)
                        shadow_slots[i] = shadow_slots[i-1];
                    shadow_slots[where] = key;
                    shadow_count++;
                    done = 1'b1;
                end
                push_beat('0, !done, pal_pkg::KIND_INSERT, 1'b1);
            end
            pal_pkg::OP_REM_AT, pal_pkg::OP_REM_FIRST, pal_pkg::OP_REM_LAST: begin
                where = (op == pal_pkg::OP_REM_FIRST) ? 0 :
                        (op == pal_pkg::OP_REM_LAST)  ?
                            ((shadow_count == 0) ? 0 : shadow_count - 1) :
                        pos;
                if (shadow_count != 0 && where < shadow_count) begin
                    taken = shadow_slots[where];
                    for (i = where; i + 1 < shadow_count; i++)
                        shadow_slots[i] = shadow_slots[i+1];
                    shadow_count--;
                    done = 1'b1;
                end
                push_beat(taken, !done, pal_pkg::KIND_REMOVE, 1'b1);
            end
            default: begin
                // list, and the spare opcode which behaves the same
                for (i = 0; i < shadow_count; i++)
                    push_beat(shadow_slots[i], 1'b0, pal_pkg::KIND_LIST,
                              i == shadow_count - 1);
            end
        endcase
    endtask

    task automatic check_field(input string what, input logic [pal_pkg::KEY_W-1:0] want,
                               input logic [pal_pkg::KEY_W-1:0] got);
        if (want !== got) begin
            o_errors++;
            $display("%0t: %s expected %h actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            awaited_beats.delete();
            shadow_count = 0;
            shadow_cap   = 16;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_beats_seen++;
                if (awaited_beats.size() == 0) begin
                    o_errors++;
                    $display("%0t: result beat expected none actual key %h kind %0d",
                             $time, i_key_out, i_result_kind);
                end else begin
                    oldest_beat = awaited_beats.pop_front();
                    check_field("key_out", oldest_beat.key, i_key_out);
                    check_field("status", pal_pkg::KEY_W'(oldest_beat.status),
                                pal_pkg::KEY_W'(i_status));
                    check_field("count_after", pal_pkg::KEY_W'(oldest_beat.count_after),
                                pal_pkg::KEY_W'(i_count_after));
                    check_field("result_kind", pal_pkg::KEY_W'(oldest_beat.kind),
                                pal_pkg::KEY_W'(i_result_kind));
                    check_field("last", pal_pkg::KEY_W'(oldest_beat.last),
                                pal_pkg::KEY_W'(i_last));
                end
            end
            // an item taken at this edge still sees the old capacity
            if (i_in_valid && !i_in_stall)
                apply_item(i_opcode, i_key_in, int'(i_position));
            if (i_cfg_we)
                shadow_cap = int'(i_cfg_data);
        end
        o_outstanding = awaited_beats.size();
        o_stored      = shadow_count;
    end

endmodule

FILE: bench/positional_array_list_top_tb.sv
// testbench top for the positional array list: clock, reset, directed and random stimulus,
// random stalls on both channels, capacity changes between phases and the final verdict
// depends on pal_pkg, positional_array_list_top and positional_array_list_checker
`timescale 1ns / 1ps

module positional_array_list_top_tb;

    localparam int CLK_PERIOD  = 8;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 60;
    // idle cycles allowed after the last expected beat before the list is treated as quiet
    localparam int SETTLE      = 4;
    // opcode seven has no package name; the block treats it as a list
    localparam logic [pal_pkg::OP_W-1:0] OP_SPARE = 3'd7;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [pal_pkg::CAP_W-1:0]      i_cfg_data;
    logic                           i_valid;
    logic                           o_stall;
    logic [pal_pkg::OP_W-1:0]       i_opcode;
    pal_pkg::t_key                  i_key_in;
    logic [pal_pkg::POS_W-1:0]      i_position;
    logic                           o_valid;
    logic                           i_stall;
    pal_pkg::t_key                  o_key_out;
    logic                           o_status;
    logic [pal_pkg::CNTO_W-1:0]     o_count_after;
    logic [pal_pkg::KIND_W-1:0]     o_result_kind;
    logic                           o_last;

    int errors;
    int outstanding;
    int list_stored;
    int beats_seen;

    int cycle_count;
    int items_sent;
    int settings_made;
    int in_gap_max;
    int out_stall_max;
    int stall_left;

    // capacity and insert share per random phase: a filling phase at full depth first,
    // a draining one halfway, settings above the depth and at zero in between
    int phase_caps [PHASES] = '{16, 3, 31, 0, 16, 1, 9, 16};
    int insert_pct [PHASES] = '{75, 55, 60, 50, 25, 50, 55, 50};

    positional_array_list_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_key_in       (i_key_in),
        .i_position     (i_position),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_key_out      (o_key_out),
        .o_status       (o_status),
        .o_count_after  (o_count_after),
        .o_result_kind  (o_result_kind),
        .o_last         (o_last)
    );

    positional_array_list_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_opcode       (i_opcode),
        .i_key_in       (i_key_in),
        .i_position     (i_position),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_key_out      (o_key_out),
        .i_status       (o_status),
        .i_count_after  (o_count_after),
        .i_result_kind  (o_result_kind),
        .i_last         (o_last),
        .o_errors       (errors),
        .o_outstanding  (outstanding),
        .o_stored       (list_stored),
        .o_beats_seen   (beats_seen)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still awaited",
                     cycle_count, outstanding);
            $display("positional_array_list_top_tb: done, errors");
            $finish;
        end
    end

    // receiver side: a fresh stall length is drawn for every beat taken,
    // counted down on falling edges so i_stall only moves between rising edges
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall = 1'b1;
            stall_left--;
        end else begin
            i_stall = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (o_valid && !i_stall)
            stall_left = (out_stall_max == 0) ? 0 : $urandom_range(0, out_stall_max);
    end

    // sender side: entered and left on a falling edge; valid stays high across
    // back-to-back beats and the payload only moves once the beat is taken
    task automatic send_item(input logic [pal_pkg::OP_W-1:0] op, input pal_pkg::t_key key,
                             input logic [pal_pkg::POS_W-1:0] pos);
        int gap;
        gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    = 1'b1;
        i_opcode   = op;
        i_key_in   = key;
        i_position = pos;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (outstanding != 0) @(negedge i_clk);
    endtask

    // capacity is only changed with the list quiet: input idle, every beat back,
    // then a short settle in case the last item was a list of nothing
    task automatic set_capacity(input logic [pal_pkg::CAP_W-1:0] value);
        i_valid = 1'b0;
        wait_drained();
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        settings_made++;
    endtask

    // mostly in-range positions against the shadow count, now and then any byte
    task automatic random_item(input int ins_pct);
        int                          roll;
        int                          stored;
        logic [pal_pkg::OP_W-1:0]    op;
        logic [pal_pkg::POS_W-1:0]   pos;
        pal_pkg::t_key               key;
        stored = list_stored;
        roll   = $urandom_range(0, 99);
        key    = $urandom;
        pos    = pal_pkg::POS_W'($urandom_range(0, 255));
        if (roll < ins_pct) begin
            case ($urandom_range(0, 2))
                0:       op = pal_pkg::OP_INS_AT;
                1:       op = pal_pkg::OP_INS_FIRST;
                default: op = pal_pkg::OP_INS_LAST;
            endcase
            if ($urandom_range(0, 9) != 0)
                pos = pal_pkg::POS_W'($urandom_range(0, stored));
        end else if (roll < 94) begin
            case ($urandom_range(0, 2))
                0:       op = pal_pkg::OP_REM_AT;
                1:       op = pal_pkg::OP_REM_FIRST;
                default: op = pal_pkg::OP_REM_LAST;
            endcase
            if (stored > 0 && $urandom_range(0, 9) != 0)
                pos = pal_pkg::POS_W'($urandom_range(0, stored - 1));
        end else begin
            op = $urandom_range(0, 1) ? pal_pkg::OP_LIST : OP_SPARE;
        end
        send_item(op, key, pos);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_opcode      = pal_pkg::OP_LIST;
        i_key_in      = '0;
        i_position    = '0;
        i_stall       = 1'b0;
        stall_left    = 0;
        in_gap_max    = 4;
        out_stall_max = 4;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty list: every remove is refused, a list gives nothing
        send_item(pal_pkg::OP_REM_FIRST, '0, 8'd0);
        send_item(pal_pkg::OP_REM_LAST, '0, 8'd0);
        send_item(pal_pkg::OP_REM_AT, '0, 8'd0);
        send_item(pal_pkg::OP_LIST, '0, 8'd0);
        // insert past the count is refused
        send_item(pal_pkg::OP_INS_AT, 32'h1234_5678, 8'd1);
        // extreme keys, position at the count, position far out of range
        send_item(pal_pkg::OP_INS_FIRST, 32'h7FFF_FFFF, 8'd0);
        send_item(pal_pkg::OP_INS_LAST, 32'h8000_0000, 8'd0);
        send_item(pal_pkg::OP_INS_AT, 32'hFFFF_FFFF, 8'd1);
        send_item(pal_pkg::OP_INS_AT, 32'h0BAD_0BAD, 8'd255);
        send_item(pal_pkg::OP_INS_AT, 32'h0000_0000, 8'd3);
        send_item(pal_pkg::OP_LIST, '0, 8'd0);
        // remove at the count and far past it
        send_item(pal_pkg::OP_REM_AT, '0, 8'd4);
        send_item(pal_pkg::OP_REM_AT, '0, 8'd255);
        send_item(pal_pkg::OP_REM_AT, '0, 8'd1);
        send_item(OP_SPARE, '0, 8'd0);
        send_item(pal_pkg::OP_REM_LAST, '0, 8'd0);

        // capacity dropped below the count: full for inserts, removes still work
        set_capacity(5'd1);
        send_item(pal_pkg::OP_INS_FIRST, 32'h5555_AAAA, 8'd0);
        send_item(pal_pkg::OP_REM_FIRST, '0, 8'd0);
        send_item(pal_pkg::OP_INS_LAST, 32'hAAAA_5555, 8'd0);
        // zero capacity refuses every insert
        set_capacity(5'd0);
        send_item(pal_pkg::OP_INS_AT, 32'h0F0F_0F0F, 8'd0);
        send_item(pal_pkg::OP_REM_LAST, '0, 8'd0);
        send_item(pal_pkg::OP_INS_FIRST, 32'hF0F0_F0F0, 8'd0);
        send_item(pal_pkg::OP_LIST, '0, 8'd0);

        // random phases, with idling on neither, one or both sides
        for (int ph = 0; ph < PHASES; ph++) begin
            set_capacity(phase_caps[ph][pal_pkg::CAP_W-1:0]);
            in_gap_max    = ph[0] ? 16 : 0;
            out_stall_max = ph[1] ? 16 : 0;
            repeat (PHASE_ITEMS) random_item(insert_pct[ph]);
        end

        i_valid = 1'b0;
        wait_drained();
        repeat (4 * SETTLE) @(negedge i_clk);

        $display("%0d input beats and %0d result beats checked over %0d capacity settings",
                 items_sent, beats_seen, settings_made + 1);
        $display("shadow list holds %0d keys at the end, %0d mismatches", list_stored, errors);
        if (errors == 0 && outstanding == 0) begin
            $display("positional_array_list_top_tb: done, clean");
        end else begin
            $display("positional_array_list_top_tb: done, errors");
        end
        $finish;
    end

endmodule
